### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define ASSERT_HOLDS(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication, clocked on clk_i, off during reset
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

### rtl/wpf_pkg.sv
`timescale 1ns / 1ps
package wpf_pkg;

  localparam int NumSlots    = 16;
  localparam int SlotW       = $clog2(NumSlots);
  localparam int CountW      = 5;
  localparam int CordicSteps = 16;
  localparam int IterW       = $clog2(CordicSteps);
  localparam int AngPi       = 25736;
  localparam int AngTwoPi    = 51472;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 32;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_COUNT  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GOAL   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HEAD   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GLIN   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_GANG   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_SPEED  = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_TURN   = 3'd7;

  // actions
  localparam logic [1:0] ACT_POSE = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_WP   = 2'd2;

  // events
  localparam logic [1:0] EV_MOVE   = 2'd0;
  localparam logic [1:0] EV_REACH  = 2'd1;
  localparam logic [1:0] EV_DONE   = 2'd2;
  localparam logic [1:0] EV_FINISH = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic signed [15:0] heading;
    logic [3:0]         slot;
  } in_item_t;

  typedef struct packed {
    logic [14:0]        linear_speed;
    logic signed [15:0] turn_rate;
    logic [3:0]         target_slot;
    logic               phase;
    logic [1:0]         event_res;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  waypoint_count;
    logic        repeat_mode;
    logic [23:0] goal_distance_tol;
    logic [14:0] heading_tol;
    logic [15:0] gain_linear;
    logic [15:0] gain_angular;
    logic [14:0] speed_limit;
    logic [14:0] turn_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_READ, OP_DIFF, OP_SQX, OP_SQY, OP_START,
    OP_ERR, OP_MTURN, OP_MSPEED, OP_CLAMP
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic             pose_we;
    logic             wp_we;
    logic [SlotW-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic               busy;
    logic               near;
    logic               steer_ok;
    logic               align_ok;
    logic [14:0]        speed;
    logic signed [15:0] turn;
  } sts_t;

  // arctan(2^-i) at 2^-24 rad
  function automatic logic signed [28:0] atan_val(input logic [4:0] idx);
    logic signed [28:0] v;
    case (idx)
      5'd0:  v = 29'sd13176795;
      5'd1:  v = 29'sd7778716;
      5'd2:  v = 29'sd4110060;
      5'd3:  v = 29'sd2086331;
      5'd4:  v = 29'sd1047214;
      5'd5:  v = 29'sd524117;
      5'd6:  v = 29'sd262123;
      5'd7:  v = 29'sd131069;
      5'd8:  v = 29'sd65536;
      5'd9:  v = 29'sd32768;
      5'd10: v = 29'sd16384;
      5'd11: v = 29'sd8192;
      5'd12: v = 29'sd4096;
      5'd13: v = 29'sd2048;
      5'd14: v = 29'sd1024;
      5'd15: v = 29'sd512;
      5'd16: v = 29'sd256;
      5'd17: v = 29'sd128;
      5'd18: v = 29'sd64;
      5'd19: v = 29'sd32;
      5'd20: v = 29'sd16;
      5'd21: v = 29'sd8;
      5'd22: v = 29'sd4;
      5'd23: v = 29'sd2;
      default: v = 29'sd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/waypoint_pose_follower_top.sv
`timescale 1ns / 1ps
// waypoint pose follower: two-phase proportional go-to-goal controller
// input channel (in_valid_i / in_stall_o): one item per accept, action selects
//   pose update, control tick or waypoint write
// pose updates and waypoint writes give no result and do not stall the input
// a control tick while the patrol is active and the waypoint count is nonzero
//   gives one result item on the output channel (out_valid_o / out_stall_i);
//   other ticks give none
// an approach tick steps through read, difference, both squares and start,
//   then waits while the 32-step square root and, beside it, the cordic
//   bearing run, the square root setting the wait; error, multiply and clamp
//   steps follow; an aligning tick skips both units; the input stalls while a
//   tick is being worked, so the next item is taken only once it is through
// the result sits in an output register; a stalled receiver holds it there and
//   the next item is still taken, only a later tick waits for the register
// config port (cfg_valid_i / cfg_ready_o) is always ready, write while idle
// reset clears pose, patrol flags and slot and loads register defaults;
//   the waypoint store is not cleared and must be written before use
module waypoint_pose_follower_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  wpf_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output wpf_pkg::out_item_t              out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wpf_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [wpf_pkg::CfgDataW-1:0]    cfg_data_i
);
  import wpf_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  // config registers, values masked to field width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.waypoint_count    <= 5'd1;
      cfg_q.repeat_mode       <= 1'b1;
      cfg_q.goal_distance_tol <= 24'd13107;
      cfg_q.heading_tol       <= 15'd819;
      cfg_q.gain_linear       <= 16'd4096;
      cfg_q.gain_angular      <= 16'd8192;
      cfg_q.speed_limit       <= 15'd2048;
      cfg_q.turn_limit        <= 15'd4096;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_COUNT:  cfg_q.waypoint_count    <= cfg_data_i[4:0];
        CFG_REPEAT: cfg_q.repeat_mode       <= cfg_data_i[0];
        CFG_GOAL:   cfg_q.goal_distance_tol <= cfg_data_i[23:0];
        CFG_HEAD:   cfg_q.heading_tol       <= cfg_data_i[14:0];
        CFG_GLIN:   cfg_q.gain_linear       <= cfg_data_i[15:0];
        CFG_GANG:   cfg_q.gain_angular      <= cfg_data_i[15:0];
        CFG_SPEED:  cfg_q.speed_limit       <= cfg_data_i[14:0];
        CFG_TURN:   cfg_q.turn_limit        <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // sequencer: patrol flags, tick steps, output register
  wpf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // pose, waypoint store, multiplier, sqrt and cordic units
  wpf_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_item_i (in_item_i),
    .cmd_i     (cmd),
    .sts_o     (sts)
  );

endmodule

### rtl/wpf_dp.sv
`timescale 1ns / 1ps
module wpf_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wpf_pkg::cfg_t     cfg_i,
  input  wpf_pkg::in_item_t in_item_i,
  input  wpf_pkg::cmd_t     cmd_i,
  output wpf_pkg::sts_t     sts_o
);
  import wpf_pkg::*;

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_NORM = 2'd1;
  localparam logic [1:0] C_ITER = 2'd2;

  localparam logic signed [32:0] MagMax = 33'sh0_7FFF_FFFF;
  localparam logic signed [17:0] PiA    = 18'(AngPi);
  localparam logic signed [17:0] TwoPiA = 18'(AngTwoPi);

  function automatic logic signed [17:0] wrap(input logic signed [17:0] a);
    logic signed [17:0] r;
    r = a;
    if (a > PiA) r = a - TwoPiA;
    else if (a < -PiA) r = a + TwoPiA;
    return r;
  endfunction

  logic signed [31:0] pose_x_q, pose_y_q;
  logic signed [15:0] pose_h_q;
  logic [79:0]        wp_mem [NumSlots];
  logic [79:0]        wp_q;
  logic signed [32:0] dx_q, dy_q;
  logic               sat_q;
  logic signed [17:0] err_q;
  logic [63:0]        acc_q;
  logic signed [65:0] prod_q;
  logic signed [15:0] turn_q;
  logic [14:0]        speed_q;

  // sqrt unit
  logic [63:0] rad_q;
  logic [34:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  sq_cnt_q;
  logic        sq_busy_q;

  // cordic unit
  logic [1:0]         cst_q;
  logic signed [39:0] cx_q, cy_q;
  logic signed [28:0] cz_q;
  logic [IterW-1:0]   ci_q;

  logic signed [31:0] wx, wy;
  logic signed [15:0] wh;
  logic signed [32:0] dx_w, dy_w;
  logic signed [32:0] mul_a, mul_b;
  logic [31:0]        dist_val;
  logic signed [17:0] bear, emag_s;
  logic [16:0]        emag;

  assign wx = wp_q[79:48];
  assign wy = wp_q[47:16];
  assign wh = wp_q[15:0];
  assign dx_w = {wx[31], wx} - {pose_x_q[31], pose_x_q};
  assign dy_w = {wy[31], wy} - {pose_y_q[31], pose_y_q};
  assign dist_val = sat_q ? 32'h8000_0000 : root_q;
  assign bear = 18'((cz_q + 29'sd1024) >>> 11);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_x_q <= '0;
      pose_y_q <= '0;
      pose_h_q <= '0;
    end else if (cmd_i.pose_we) begin
      pose_x_q <= in_item_i.x_pos;
      pose_y_q <= in_item_i.y_pos;
      pose_h_q <= in_item_i.heading;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wp_we) wp_mem[cmd_i.slot] <= {in_item_i.x_pos, in_item_i.y_pos, in_item_i.heading};
    if (cmd_i.op == OP_READ) wp_q <= wp_mem[cmd_i.slot];
  end

  always_comb begin
    mul_a = dx_q;
    mul_b = dx_q;
    case (cmd_i.op)
      OP_SQY: begin
        mul_a = dy_q;
        mul_b = dy_q;
      end
      OP_MTURN: begin
        mul_a = {17'b0, cfg_i.gain_angular};
        mul_b = {{15{err_q[17]}}, err_q};
      end
      OP_MSPEED: begin
        mul_a = {17'b0, cfg_i.gain_linear};
        mul_b = {1'b0, dist_val};
      end
      default: begin
        mul_a = dx_q;
        mul_b = dx_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    logic signed [65:0] t;
    logic signed [65:0] tl;
    logic [49:0]        v;
    t  = prod_q >>> 13;
    tl = {51'b0, cfg_i.turn_limit};
    v  = prod_q[65:16];
    case (cmd_i.op)
      OP_DIFF: begin
        dx_q  <= dx_w;
        dy_q  <= dy_w;
        sat_q <= (dx_w > MagMax) || (dx_w < -MagMax) || (dy_w > MagMax) || (dy_w < -MagMax);
        err_q <= wrap({{2{wh[15]}}, wh} - {{2{pose_h_q[15]}}, pose_h_q});
      end
      OP_SQX: prod_q <= mul_a * mul_b;
      OP_SQY: begin
        acc_q  <= prod_q[63:0];
        prod_q <= mul_a * mul_b;
      end
      OP_ERR: err_q <= wrap(bear - {{2{pose_h_q[15]}}, pose_h_q});
      OP_MTURN: prod_q <= mul_a * mul_b;
      OP_MSPEED: begin
        if (t > tl) turn_q <= {1'b0, cfg_i.turn_limit};
        else if (t < -tl) turn_q <= -$signed({1'b0, cfg_i.turn_limit});
        else turn_q <= t[15:0];
        prod_q <= mul_a * mul_b;
      end
      OP_CLAMP: speed_q <= (v > {35'b0, cfg_i.speed_limit}) ? cfg_i.speed_limit : v[14:0];
      default: ;
    endcase
  end

  // digit-by-digit square root, one result bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [34:0] remn, trial;
    remn  = {rem_q[32:0], rad_q[63:62]};
    trial = {1'b0, root_q, 2'b01};
    if (!rst_ni) begin
      sq_busy_q <= 1'b0;
      sq_cnt_q  <= '0;
    end else if (cmd_i.op == OP_START) begin
      rad_q     <= acc_q + prod_q[63:0];
      rem_q     <= '0;
      root_q    <= '0;
      sq_cnt_q  <= '0;
      sq_busy_q <= 1'b1;
    end else if (sq_busy_q) begin
      rad_q <= {rad_q[61:0], 2'b00};
      if (remn >= trial) begin
        rem_q  <= remn - trial;
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q  <= remn;
        root_q <= {root_q[30:0], 1'b0};
      end
      sq_cnt_q <= sq_cnt_q + 5'd1;
      if (sq_cnt_q == 5'd31) sq_busy_q <= 1'b0;
    end
  end

  // vectoring cordic: normalize, fold left half plane, then rotate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic signed [39:0] ax, ay, m, sx, sy;
    ax = cx_q[39] ? -cx_q : cx_q;
    ay = cy_q[39] ? -cy_q : cy_q;
    m  = (ax > ay) ? ax : ay;
    sx = cx_q >>> ci_q;
    sy = cy_q >>> ci_q;
    if (!rst_ni) begin
      cst_q <= C_IDLE;
      cz_q  <= '0;
      ci_q  <= '0;
    end else begin
      case (cst_q)
        C_IDLE: begin
          if (cmd_i.op == OP_START) begin
            if (dx_q == 33'sd0 && dy_q == 33'sd0) begin
              cz_q <= '0;
            end else begin
              cx_q  <= {{7{dx_q[32]}}, dx_q};
              cy_q  <= {{7{dy_q[32]}}, dy_q};
              cst_q <= C_NORM;
            end
          end
        end
        C_NORM: begin
          if (m < 40'sh00_0100_0000) begin
            cx_q <= cx_q <<< 8;
            cy_q <= cy_q <<< 8;
          end else if (m < 40'sh01_0000_0000) begin
            cx_q <= cx_q <<< 1;
            cy_q <= cy_q <<< 1;
          end else begin
            if (cx_q < 0) begin
              if (cy_q >= 0) begin
                cx_q <= cy_q;
                cy_q <= -cx_q;
                cz_q <= atan_val(5'd0) <<< 1;
              end else begin
                cx_q <= -cy_q;
                cy_q <= cx_q;
                cz_q <= -(atan_val(5'd0) <<< 1);
              end
            end else begin
              cz_q <= '0;
            end
            ci_q  <= '0;
            cst_q <= C_ITER;
          end
        end
        C_ITER: begin
          if (cy_q > 0) begin
            cx_q <= cx_q + sy;
            cy_q <= cy_q - sx;
            cz_q <= cz_q + atan_val(5'(ci_q));
          end else begin
            cx_q <= cx_q - sy;
            cy_q <= cy_q + sx;
            cz_q <= cz_q - atan_val(5'(ci_q));
          end
          if (ci_q == IterW'(CordicSteps - 1)) cst_q <= C_IDLE;
          else ci_q <= ci_q + 1'b1;
        end
        default: cst_q <= C_IDLE;
      endcase
    end
  end

  assign emag_s = err_q[17] ? -err_q : err_q;
  assign emag   = emag_s[16:0];

  assign sts_o.busy     = sq_busy_q || (cst_q != C_IDLE);
  assign sts_o.near     = dist_val < {8'b0, cfg_i.goal_distance_tol};
  assign sts_o.steer_ok = emag <= {2'b0, cfg_i.heading_tol};
  assign sts_o.align_ok = emag < {2'b0, cfg_i.heading_tol};
  assign sts_o.speed    = speed_q;
  assign sts_o.turn     = turn_q;

endmodule

### rtl/wpf_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wpf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wpf_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  input  wpf_pkg::in_item_t  in_item_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wpf_pkg::out_item_t out_item_o,
  input  wpf_pkg::sts_t      sts_i,
  output wpf_pkg::cmd_t      cmd_o
);
  import wpf_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_READ   = 4'd1;
  localparam logic [3:0] S_DIFF   = 4'd2;
  localparam logic [3:0] S_SQX    = 4'd3;
  localparam logic [3:0] S_SQY    = 4'd4;
  localparam logic [3:0] S_START  = 4'd5;
  localparam logic [3:0] S_WAIT   = 4'd6;
  localparam logic [3:0] S_ERR    = 4'd7;
  localparam logic [3:0] S_MTURN  = 4'd8;
  localparam logic [3:0] S_MSPEED = 4'd9;
  localparam logic [3:0] S_CLAMP  = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0]       state_q, state_d;
  logic [SlotW-1:0] cur_q;
  logic             active_q, align_q, finished_q, phase_q;
  logic             out_valid_q;
  out_item_t        out_q, out_d;
  logic [CountW-1:0] n, nxt;
  logic             accept, out_load;

  assign n = (cfg_i.waypoint_count > CountW'(NumSlots)) ? CountW'(NumSlots)
                                                        : cfg_i.waypoint_count;
  assign nxt        = CountW'(cur_q) + CountW'(1);
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    cmd_o.op      = OP_NONE;
    cmd_o.pose_we = accept && (in_item_i.action == ACT_POSE);
    cmd_o.wp_we   = accept && (in_item_i.action == ACT_WP);
    cmd_o.slot    = (state_q == S_IDLE) ? in_item_i.slot[SlotW-1:0] : cur_q;
    case (state_q)
      S_READ:   cmd_o.op = OP_READ;
      S_DIFF:   cmd_o.op = OP_DIFF;
      S_SQX:    cmd_o.op = OP_SQX;
      S_SQY:    cmd_o.op = OP_SQY;
      S_START:  cmd_o.op = OP_START;
      S_ERR:    cmd_o.op = OP_ERR;
      S_MTURN:  cmd_o.op = OP_MTURN;
      S_MSPEED: cmd_o.op = OP_MSPEED;
      S_CLAMP:  cmd_o.op = OP_CLAMP;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && in_item_i.action == ACT_TICK && active_q && n != '0) state_d = S_READ;
      end
      S_READ:   state_d = S_DIFF;
      S_DIFF:   state_d = phase_q ? S_MTURN : S_SQX;
      S_SQX:    state_d = S_SQY;
      S_SQY:    state_d = S_START;
      S_START:  state_d = S_WAIT;
      S_WAIT:   if (!sts_i.busy) state_d = S_ERR;
      S_ERR:    state_d = S_MTURN;
      S_MTURN:  state_d = S_MSPEED;
      S_MSPEED: state_d = S_CLAMP;
      S_CLAMP:  state_d = S_OUT;
      S_OUT:    if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // result of the tick
  always_comb begin
    out_d.linear_speed = '0;
    out_d.turn_rate    = '0;
    out_d.target_slot  = 4'(cur_q);
    out_d.phase        = phase_q;
    out_d.event_res    = EV_MOVE;
    if (!phase_q) begin
      if (sts_i.near) begin
        out_d.event_res = EV_REACH;
      end else begin
        out_d.turn_rate = sts_i.turn;
        if (sts_i.steer_ok) out_d.linear_speed = sts_i.speed;
      end
    end else begin
      if (sts_i.align_ok) begin
        if (nxt >= n && !cfg_i.repeat_mode) out_d.event_res = EV_FINISH;
        else out_d.event_res = EV_DONE;
      end else begin
        out_d.turn_rate = sts_i.turn;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      active_q    <= 1'b0;
      align_q     <= 1'b0;
      finished_q  <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (accept && in_item_i.action == ACT_POSE && !active_q && !finished_q && n != '0)
        active_q <= 1'b1;
      if (state_q == S_IDLE && state_d == S_READ) begin
        // slot at or beyond the count restarts the patrol
        if (CountW'(cur_q) >= n) begin
          cur_q   <= '0;
          align_q <= 1'b0;
          phase_q <= 1'b0;
        end else begin
          phase_q <= align_q;
        end
      end
      if (out_load) begin
        if (!phase_q) begin
          if (sts_i.near) align_q <= 1'b1;
        end else if (sts_i.align_ok) begin
          align_q <= 1'b0;
          if (nxt >= n) begin
            if (cfg_i.repeat_mode) begin
              cur_q <= '0;
            end else begin
              active_q   <= 1'b0;
              finished_q <= 1'b1;
            end
          end else begin
            cur_q <= nxt[SlotW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `ASSERT_HOLDS(a_fin_inactive, finished_q, !active_q)
  `ASSERT_HOLDS(a_tick_active, state_q != S_IDLE, active_q)
  `ASSERT_NEXT(a_load_idle, out_load, state_q == S_IDLE && out_valid_q)
  `ASSERT_NEXT(a_finish_flags, out_load && out_d.event_res == EV_FINISH, finished_q && !active_q)

endmodule
